@@ sv/poly_cv_shift_register_assert.svh @@
// Assertion macros for the shift register RTL.
`ifndef POLY_CV_SHIFT_REGISTER_ASSERT_SVH
`define POLY_CV_SHIFT_REGISTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCVSR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCVSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pcvsr_pkg.sv @@
// Shared types and constants of the polyphonic CV shift register.
package pcvsr_pkg;

  localparam int MV_W   = 15;
  localparam int CNT_W  = 5;
  localparam int CHAN_W = 4;
  localparam int STG_W  = 3;

  localparam logic signed [MV_W-1:0] MV_LIMIT_P    = 15'sd12000;
  localparam logic signed [MV_W-1:0] MV_LIMIT_N    = -15'sd12000;
  localparam logic signed [MV_W-1:0] TRIG_HIGH_RST = 15'sd1000;
  localparam logic signed [MV_W-1:0] TRIG_LOW_RST  = 15'sd0;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TRIG_HIGH = 1'b0,
    REG_TRIG_LOW  = 1'b1
  } cfg_reg_t;

  // One column walk handed from the control side to the sequencer
  typedef struct packed {
    logic              start;
    logic [CHAN_W-1:0] chan;
    logic [MV_W-1:0]   cv;
  } job_t;

  // Per-stage answer from the control side for the stage being written
  typedef struct packed {
    logic             copy_ok;
    logic [CNT_W-1:0] stage_chans;
  } view_t;

endpackage

@@ sv/pcvsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pcvsr_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/pcvsr_ctrl.sv @@
// Trigger detection, stage channel counts and per-word job set-up.
module pcvsr_ctrl #(
  parameter int STAGES   = 8,
  parameter int CHANNELS = 16,
  localparam int SW = $clog2(STAGES)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic                                   cfg_idx,
  input  logic [pcvsr_pkg::MV_W-1:0]             cfg_data,
  input  logic                                   acc,
  input  logic [pcvsr_pkg::CHAN_W-1:0]           chan,
  input  logic signed [pcvsr_pkg::MV_W-1:0]      trig_mv,
  input  logic signed [pcvsr_pkg::MV_W-1:0]      in_mv,
  input  logic [pcvsr_pkg::CNT_W-1:0]            trig_count,
  input  logic [pcvsr_pkg::CNT_W-1:0]            in_count,
  input  logic                                   tick_end,
  input  logic [SW-1:0]                          q_stg,
  output pcvsr_pkg::job_t                        job,
  output pcvsr_pkg::view_t                       view
);

  localparam int CW     = pcvsr_pkg::CNT_W;
  localparam int MW     = pcvsr_pkg::MV_W;
  localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TRIG_N = 2 ** CHW;
  localparam logic [CW-1:0] CH_CNT = CW'(CHANNELS);

  typedef enum logic [2:0] {
    MODE_NONE   = 3'b001,
    MODE_SINGLE = 3'b010,
    MODE_MULTI  = 3'b100
  } mode_t;

  logic signed [MW-1:0] thr_hi_r, thr_hi_nxt;
  logic signed [MW-1:0] thr_lo_r, thr_lo_nxt;
  logic                 trig_hi_r   [TRIG_N];
  logic                 trig_hi_nxt [TRIG_N];
  logic [CW-1:0]        counts_r    [STAGES];
  logic [CW-1:0]        counts_nxt  [STAGES];
  logic [CW-1:0]        snap_r      [STAGES];
  logic [CW-1:0]        snap_nxt    [STAGES];
  logic                 shift_r, shift_nxt;
  logic                 start_r, start_nxt;
  logic [pcvsr_pkg::CHAN_W-1:0] chan_r, chan_nxt;
  logic [MW-1:0]        cv_r, cv_nxt;
  mode_t                mode_r, mode_nxt;

  logic signed [MW-1:0] cv_sat;
  logic [CW-1:0]        tc, ic;
  logic [CW-1:0]        chan_x;
  logic                 chan_ok, work, single, do_sch, armed, fire, rearm;
  logic [CHW-1:0]       sch_idx;
  logic [SW-1:0]        q_prev;

  // Saturate the word fields
  always_comb begin
    if (in_mv > pcvsr_pkg::MV_LIMIT_P) begin
      cv_sat = pcvsr_pkg::MV_LIMIT_P;
    end else if (in_mv < pcvsr_pkg::MV_LIMIT_N) begin
      cv_sat = pcvsr_pkg::MV_LIMIT_N;
    end else begin
      cv_sat = in_mv;
    end
    tc      = (trig_count > CH_CNT) ? CH_CNT : trig_count;
    ic      = (in_count > CH_CNT) ? CH_CNT : in_count;
    chan_x  = {1'b0, chan};
    chan_ok = chan_x < CH_CNT;
    work    = (tc != '0) && chan_ok;
    single  = (tc == CW'(1));
    sch_idx = chan[CHW-1:0];
    do_sch  = work && (single ? (chan == '0) : (chan_x < tc));
    armed   = trig_hi_r[sch_idx];
    fire    = !armed && (trig_mv >= thr_hi_r);
    rearm   = armed && (trig_mv <= thr_lo_r);
  end

  // Next state of thresholds, trigger flags, counts and the job
  always_comb begin
    thr_hi_nxt  = thr_hi_r;
    thr_lo_nxt  = thr_lo_r;
    trig_hi_nxt = trig_hi_r;
    counts_nxt  = counts_r;
    snap_nxt    = snap_r;
    shift_nxt   = shift_r;
    chan_nxt    = chan_r;
    cv_nxt      = cv_r;
    mode_nxt    = mode_r;
    start_nxt   = 1'b0;

    if (cfg_wr_en) begin
      unique case (pcvsr_pkg::cfg_reg_t'(cfg_idx))
        pcvsr_pkg::REG_TRIG_HIGH: thr_hi_nxt = cfg_data;
        pcvsr_pkg::REG_TRIG_LOW:  thr_lo_nxt = cfg_data;
      endcase
    end

    if (acc) begin
      if (do_sch) begin
        trig_hi_nxt[sch_idx] = armed ? !rearm : fire;
      end
      if (work) begin
        start_nxt = 1'b1;
        chan_nxt  = chan;
        cv_nxt    = cv_sat;
        if (single) begin
          if (chan == '0) begin
            shift_nxt = fire;
            if (fire) begin
              // Snapshot the counts, then shift them down one stage
              snap_nxt      = counts_r;
              counts_nxt[0] = ic;
              for (int i = 1; i < STAGES; i++) begin
                counts_nxt[i] = counts_r[i-1];
              end
            end
          end
          mode_nxt = ((chan == '0) ? fire : shift_r) ? MODE_SINGLE : MODE_NONE;
        end else begin
          shift_nxt = 1'b0;
          mode_nxt  = (do_sch && fire) ? MODE_MULTI : MODE_NONE;
          if (do_sch && fire) begin
            // Stage 0 takes the input count; each later count keeps the larger of itself and the stage before it
            counts_nxt[0] = ic;
            for (int i = 1; i < STAGES; i++) begin
              counts_nxt[i] = (counts_r[i-1] > counts_r[i]) ? counts_r[i-1] : counts_r[i];
            end
          end
        end
      end else if (tc == '0) begin
        shift_nxt = 1'b0;
      end
      if (tick_end) begin
        shift_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_hi_r <= pcvsr_pkg::TRIG_HIGH_RST;
      thr_lo_r <= pcvsr_pkg::TRIG_LOW_RST;
      for (int i = 0; i < TRIG_N; i++) begin
        trig_hi_r[i] <= 1'b0;
      end
      for (int i = 0; i < STAGES; i++) begin
        counts_r[i] <= '0;
        snap_r[i]   <= '0;
      end
      shift_r <= 1'b0;
      start_r <= 1'b0;
      mode_r  <= MODE_NONE;
    end else begin
      thr_hi_r  <= thr_hi_nxt;
      thr_lo_r  <= thr_lo_nxt;
      trig_hi_r <= trig_hi_nxt;
      counts_r  <= counts_nxt;
      snap_r    <= snap_nxt;
      shift_r   <= shift_nxt;
      start_r   <= start_nxt;
      mode_r    <= mode_nxt;
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
    cv_r   <= cv_nxt;
  end

  assign job.start = start_r;
  assign job.chan  = chan_r;
  assign job.cv    = cv_r;

  // Answer for the stage under write-back
  assign q_prev = q_stg - SW'(1);

  always_comb begin
    view.stage_chans = counts_r[q_stg];
    unique case (mode_r)
      MODE_SINGLE: begin
        if (q_stg == '0) begin
          view.copy_ok = {1'b0, chan_r} < counts_r[0];
        end else begin
          view.copy_ok = {1'b0, chan_r} < snap_r[q_prev];
        end
      end
      MODE_MULTI: view.copy_ok = 1'b1;
      MODE_NONE:  view.copy_ok = 1'b0;
      default:    view.copy_ok = 1'b0;
    endcase
  end

endmodule

@@ sv/pcvsr_seq.sv @@
// Sample memory sequencer: clear pass, column walk, write-back and output register.
`include "poly_cv_shift_register_assert.svh"

module pcvsr_seq #(
  parameter int STAGES   = 8,
  parameter int CHANNELS = 16,
  localparam int SW = $clog2(STAGES)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pcvsr_pkg::job_t                     job,
  input  pcvsr_pkg::view_t                    view,
  output logic [SW-1:0]                       q_stg,
  output logic                                busy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pcvsr_pkg::STG_W-1:0]         out_stage,
  output logic [pcvsr_pkg::CHAN_W-1:0]        out_chan,
  output logic signed [pcvsr_pkg::MV_W-1:0]   out_stage_mv,
  output logic [pcvsr_pkg::CNT_W-1:0]         out_stage_chans,
  output logic                                out_last
);

  localparam int DEPTH = STAGES * CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = pcvsr_pkg::MV_W;
  localparam logic [SW-1:0] LAST_STG = SW'(STAGES - 1);
  localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);

  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          iss_act_r, iss_act_nxt;
  logic [SW-1:0] iss_stg_r, iss_stg_nxt;
  logic          pend_r, pend_nxt;
  logic [SW-1:0] pend_stg_r;
  logic [AW-1:0] pend_addr_r;
  logic [MW-1:0] prev_r;
  logic          out_valid_r, out_valid_nxt;
  logic [pcvsr_pkg::STG_W-1:0]  out_stage_r;
  logic [pcvsr_pkg::CHAN_W-1:0] out_chan_r;
  logic [MW-1:0]                out_mv_r;
  logic [pcvsr_pkg::CNT_W-1:0]  out_chans_r;
  logic                         out_last_r;

  logic          out_free, mv, rd_go, we_item, ram_we;
  logic [AW-1:0] rd_addr, ram_waddr;
  logic [MW-1:0] ram_q, new_val, ram_wdata;

  // Handshake between read stage, write-back stage and output register
  assign out_free = !out_valid_r || !out_stall;
  assign mv       = pend_r && out_free;
  assign rd_go    = iss_act_r && (!pend_r || mv);
  assign rd_addr  = AW'(int'(iss_stg_r) * CHANNELS + int'(job.chan));
  assign busy     = clr_busy_r || job.start || iss_act_r || pend_r;
  assign q_stg    = pend_stg_r;

  // New value of the stage under write-back
  assign new_val = view.copy_ok ? ((pend_stg_r == '0) ? job.cv : prev_r) : ram_q;
  assign we_item = mv && view.copy_ok;

  // Clear pass owns the write port until it ends
  assign ram_we    = clr_busy_r || we_item;
  assign ram_waddr = clr_busy_r ? clr_addr_r : pend_addr_r;
  assign ram_wdata = clr_busy_r ? '0 : new_val;

  pcvsr_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_go),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Advance the clear pass, the stage walk and the pending slot
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      if (clr_addr_r == LAST_ADR) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
    end

    iss_act_nxt = iss_act_r;
    iss_stg_nxt = iss_stg_r;
    if (job.start) begin
      iss_act_nxt = 1'b1;
      iss_stg_nxt = '0;
    end else if (rd_go) begin
      if (iss_stg_r == LAST_STG) begin
        iss_act_nxt = 1'b0;
        iss_stg_nxt = '0;
      end else begin
        iss_stg_nxt = iss_stg_r + SW'(1);
      end
    end

    pend_nxt      = rd_go ? 1'b1 : (mv ? 1'b0 : pend_r);
    out_valid_nxt = mv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      iss_act_r   <= 1'b0;
      iss_stg_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      iss_act_r   <= iss_act_nxt;
      iss_stg_r   <= iss_stg_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the pending slot, the carried value and the output word
  always_ff @(posedge clk) begin
    if (rd_go) begin
      pend_stg_r  <= iss_stg_r;
      pend_addr_r <= rd_addr;
    end
    if (mv) begin
      prev_r      <= ram_q;
      out_stage_r <= pcvsr_pkg::STG_W'(pend_stg_r);
      out_chan_r  <= job.chan;
      out_mv_r    <= new_val;
      out_chans_r <= view.stage_chans;
      out_last_r  <= (pend_stg_r == LAST_STG);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_stage       = out_stage_r;
  assign out_chan        = out_chan_r;
  assign out_stage_mv    = out_mv_r;
  assign out_stage_chans = out_chans_r;
  assign out_last        = out_last_r;

  `PCVSR_ASSERT_IMPL(a_no_read_in_clear, clr_busy_r, !rd_go, "read issued during clear pass")
  `PCVSR_ASSERT_IMPL(a_start_when_idle, job.start, !iss_act_r && !pend_r, "job started mid walk")
  `PCVSR_ASSERT_IMPL(a_no_rw_collide, rd_go && we_item, rd_addr != pend_addr_r, "read hits written entry")
  `PCVSR_ASSERT_NEXT(a_walk_drains, mv && (pend_stg_r == LAST_STG), !pend_r, "walk did not drain")

endmodule

@@ sv/poly_cv_shift_register.sv @@
// Top level of the polyphonic CV shift register.
// Input channel: one word per polyphonic channel, channels in ascending order
// each tick, in_tick_end on the final one. A word is taken when in_valid is high
// and in_stall is low. Configuration: cfg_wr_en writes cfg_data to the Schmitt
// threshold chosen by cfg_idx (0 upper, 1 lower); write only while idle.
// Result channel: each word with the trigger connected and a channel in range
// yields STAGES words, stage 0 first, out_last on the final stage. A word is
// taken when out_valid is high and out_stall is low.
// Path: an accepted word is registered as a job, the walk reads stage 0 from the sample
// memory, and the result then enters the output register. Throughput: the sample
// memory's single read port walks the column one stage a cycle while out_stall is low,
// and a new word waits for the walk to drain. Words that yield no results are taken
// at one a cycle while in_stall is low.
// Reset: thresholds return to 1000 mV and 0 mV, counts and trigger states clear,
// then a clearing pass zeroes all STAGES * CHANNELS entries of the sample memory
// with in_stall held high.
// A stalled receiver freezes the walk at the output register; in_stall stays
// high until the current column is done.
module poly_cv_shift_register #(
  parameter int STAGES   = 8,
  parameter int CHANNELS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_idx,
  input  logic [pcvsr_pkg::MV_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pcvsr_pkg::CHAN_W-1:0]        in_chan,
  input  logic signed [pcvsr_pkg::MV_W-1:0]   in_trig_mv,
  input  logic signed [pcvsr_pkg::MV_W-1:0]   in_in_mv,
  input  logic [pcvsr_pkg::CNT_W-1:0]         in_trig_count,
  input  logic [pcvsr_pkg::CNT_W-1:0]         in_in_count,
  input  logic                                in_tick_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pcvsr_pkg::STG_W-1:0]         out_stage,
  output logic [pcvsr_pkg::CHAN_W-1:0]        out_chan,
  output logic signed [pcvsr_pkg::MV_W-1:0]   out_stage_mv,
  output logic [pcvsr_pkg::CNT_W-1:0]         out_stage_chans,
  output logic                                out_last
);

  localparam int SW = $clog2(STAGES);

  pcvsr_pkg::job_t  job;
  pcvsr_pkg::view_t view;
  logic [SW-1:0]    q_stg;
  logic             busy;
  logic             in_acc;

  // Hold off input words while the clear pass or a column walk runs
  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;

  pcvsr_ctrl #(
    .STAGES   (STAGES),
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .acc        (in_acc),
    .chan       (in_chan),
    .trig_mv    (in_trig_mv),
    .in_mv      (in_in_mv),
    .trig_count (in_trig_count),
    .in_count   (in_in_count),
    .tick_end   (in_tick_end),
    .q_stg      (q_stg),
    .job        (job),
    .view       (view)
  );

  pcvsr_seq #(
    .STAGES   (STAGES),
    .CHANNELS (CHANNELS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .job             (job),
    .view            (view),
    .q_stg           (q_stg),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_stage       (out_stage),
    .out_chan        (out_chan),
    .out_stage_mv    (out_stage_mv),
    .out_stage_chans (out_stage_chans),
    .out_last        (out_last)
  );

endmodule
